/* rtl/bfa_pkg.sv */
// shared types and constants for the bitmap frame allocator
// opcodes, controller states, config indexes and control/status bundles
package bfa_pkg;

  localparam int unsigned FRAMES_DEF      = 4096;
  localparam int unsigned FRAME_BYTES_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned UMK_W      = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MEM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_END   = 1'd1;

  localparam int unsigned FADDR_W  = 24;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 56;

  localparam logic [31:0] LOW_MEM_BYTES = 32'h0010_0000;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic init_load;
    logic init_wr;
    logic init_end;
    logic scan_rd;
    logic alloc_wr;
    logic free_rd;
    logic free_wr;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic cnt_last;
    logic issue_done;
    logic rd_vld;
    logic rd_last;
    logic hit;
    logic free_in_range;
    logic free_bit_used;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/bfa_ctrl.sv */
// controller state machine of the bitmap frame allocator
// depends on bfa_pkg; drives the datapath through ctl_cmd_t
module bfa_ctrl import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  op_e      in_op_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_op_i)
            OP_INIT: begin
              cmd_o.init_load = 1'b1;
              state_d = ST_INIT;
            end
            OP_ALLOC: begin
              state_d = stat_i.total_zero ? ST_DONE : ST_SCAN;
            end
            OP_FREE: begin
              state_d = ST_FREE_RD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.init_end = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = !stat_i.issue_done;
        if (stat_i.rd_vld && stat_i.hit) begin
          cmd_o.scan_rd  = 1'b0;
          cmd_o.alloc_wr = 1'b1;
          state_d = ST_DONE;
        end else if (stat_i.rd_vld && stat_i.rd_last) begin
          state_d = ST_DONE;
        end
      end
      ST_FREE_RD: begin
        if (stat_i.free_in_range) begin
          cmd_o.free_rd = 1'b1;
          state_d = ST_FREE_CHK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FREE_CHK: begin
        cmd_o.free_wr = stat_i.free_bit_used;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bfa_dp.sv */
// datapath of the bitmap frame allocator: bitmap memory, counters, result register
// depends on bfa_pkg; controlled by bfa_ctrl through ctl_cmd_t / dp_stat_t
module bfa_dp import bfa_pkg::*; #(
  parameter int unsigned FRAMES      = FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UMK_W-1:0] upper_mem_kib_i,
  input  logic [31:0]      img_end_i,
  input  logic [31:0]      free_address_i,
  input  ctl_cmd_t         cmd_i,
  output dp_stat_t         stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  localparam int unsigned WORDS = (FRAMES + 31) / 32;
  localparam int unsigned FW    = $clog2(FRAMES + 1);
  localparam int unsigned FBW   = $clog2(FRAME_BYTES);
  localparam int unsigned SFW   = 32 - FBW;
  localparam int unsigned WCW   = $clog2(WORDS + 1);
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [31:0]    map_mem [WORDS];
  logic [31:0]    rd_data_q;
  logic           rd_vld_q;
  logic [WAW-1:0] rd_idx_q;
  logic           rd_en;
  logic [WAW-1:0] rd_addr;
  logic           wr_en;
  logic [WAW-1:0] wr_addr;
  logic [31:0]    wr_data;

  logic [WCW-1:0] wcnt_q;
  logic [SFW-1:0] fidx_q;
  logic [SFW-1:0] start_q;
  logic [FW-1:0]  frame_total_q;
  logic [FW-1:0]  free_total_q;
  logic [FADDR_W-1:0] res_addr_q;
  logic           res_ok_q;
  logic           out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic [31:0] bytes;
  logic [31:0] tot_raw;
  logic [FW-1:0] tot_new;
  logic [31:0] kend_up;
  logic [31:0] rend;
  logic [31:0] base32;
  logic [31:0] start32;
  logic [31:0] tot32;
  logic [31:0] fidx32;
  logic [31:0] lo_mask;
  logic [31:0] hi_mask;
  logic [31:0] init_word;
  logic [4:0]  pe_bit;
  logic [31:0] alloc_frame;
  logic [4:0]  free_bit;

  // init sizing
  assign bytes   = 32'((33'(upper_mem_kib_i) + 33'd1024) << 10);
  assign tot_raw = bytes >> FBW;
  assign tot_new = (tot_raw > 32'(FRAMES)) ? FW'(FRAMES) : FW'(tot_raw);
  assign kend_up = (img_end_i + 32'(FRAME_BYTES - 1)) & ~32'(FRAME_BYTES - 1);
  assign rend    = kend_up + LOW_MEM_BYTES;

  // init word: frames in [start, total) are free
  assign base32  = 32'(wcnt_q) << 5;
  assign start32 = 32'(start_q);
  assign tot32   = 32'(frame_total_q);

  always_comb begin
    if (start32 <= base32) begin
      lo_mask = '1;
    end else if (start32 >= base32 + 32'd32) begin
      lo_mask = '0;
    end else begin
      lo_mask = '1 << (start32[4:0] - base32[4:0]);
    end
    if (tot32 >= base32 + 32'd32) begin
      hi_mask = '1;
    end else if (tot32 <= base32) begin
      hi_mask = '0;
    end else begin
      hi_mask = (32'd1 << (tot32[4:0] - base32[4:0])) - 32'd1;
    end
    init_word = ~(lo_mask & hi_mask);
  end

  // lowest free frame in the word just read
  always_comb begin
    pe_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!rd_data_q[i]) begin
        pe_bit = 5'(i);
      end
    end
  end

  assign alloc_frame = (32'(rd_idx_q) << 5) | 32'(pe_bit);
  assign fidx32      = 32'(fidx_q);
  assign free_bit    = fidx_q[4:0];

  // memory ports
  always_comb begin
    rd_en   = cmd_i.scan_rd | cmd_i.free_rd;
    rd_addr = cmd_i.free_rd ? fidx32[WAW+4:5] : wcnt_q[WAW-1:0];
    wr_en   = cmd_i.init_wr | cmd_i.alloc_wr | cmd_i.free_wr;
    if (cmd_i.init_wr) begin
      wr_addr = wcnt_q[WAW-1:0];
      wr_data = init_word;
    end else if (cmd_i.alloc_wr) begin
      wr_addr = rd_idx_q;
      wr_data = rd_data_q | (32'd1 << pe_bit);
    end else begin
      wr_addr = rd_idx_q;
      wr_data = rd_data_q & ~(32'd1 << free_bit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.capture) begin
      fidx_q <= free_address_i[31:FBW];
    end
    if (cmd_i.init_load) begin
      start_q <= rend[31:FBW];
    end
    if (cmd_i.res_load) begin
      out_data_q <= OUT_W'({COUNT_W'(frame_total_q), COUNT_W'(free_total_q),
                            res_ok_q, res_addr_q});
    end
  end

  // control and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q      <= 1'b0;
      wcnt_q        <= '0;
      frame_total_q <= '0;
      free_total_q  <= '0;
      res_addr_q    <= '0;
      res_ok_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.capture) begin
        wcnt_q     <= '0;
        res_addr_q <= '0;
        res_ok_q   <= 1'b0;
      end else if (cmd_i.init_wr || cmd_i.scan_rd) begin
        wcnt_q <= wcnt_q + WCW'(1);
      end
      if (cmd_i.init_load) begin
        frame_total_q <= tot_new;
      end
      if (cmd_i.init_end) begin
        free_total_q <= (tot32 > start32) ? FW'(tot32 - start32) : '0;
      end else if (cmd_i.alloc_wr) begin
        free_total_q <= free_total_q - FW'(1);
      end else if (cmd_i.free_wr) begin
        free_total_q <= free_total_q + FW'(1);
      end
      if (cmd_i.alloc_wr) begin
        res_addr_q <= FADDR_W'(alloc_frame << FBW);
        res_ok_q   <= 1'b1;
      end else if (cmd_i.free_wr) begin
        res_ok_q <= 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.total_zero    = (frame_total_q == '0);
    stat_o.cnt_last      = (wcnt_q == WCW'(WORDS - 1));
    stat_o.issue_done    = (wcnt_q == WCW'(WORDS));
    stat_o.rd_vld        = rd_vld_q;
    stat_o.rd_last       = (rd_idx_q == WAW'(WORDS - 1));
    stat_o.hit           = (rd_data_q != '1);
    stat_o.free_in_range = (fidx32 < tot32);
    stat_o.free_bit_used = rd_data_q[free_bit];
    stat_o.out_busy      = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/bitmap_frame_allocator.sv */
// init and alloc walk the bitmap memory one word per cycle; free touches a single word
// throughput: one transaction in flight; the next is taken once the result is registered
// reset (rst_ni low, async) clears counts and config; bitmap content is rebuilt by init
// depends on bfa_pkg, bfa_ctrl and bfa_dp
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int unsigned FRAMES      = FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // opcode[1:0], free_address[33:2], zero pad
  input  logic [IN_W-1:0]       s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // frame_address[23:0], ok[24], free_count[37:25], total_count[50:38], zero pad
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  logic [UMK_W-1:0] upper_mem_kib_q;
  logic [31:0]      img_end_q;
  ctl_cmd_t         cmd;
  dp_stat_t         stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_mem_kib_q <= '0;
      img_end_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UPPER_MEM: upper_mem_kib_q <= cfg_wdata_i[UMK_W-1:0];
        CFG_IMG_END:   img_end_q       <= cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (op_e'(s_axis_tdata_i[1:0])),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfa_dp #(
    .FRAMES      (FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upper_mem_kib_i (upper_mem_kib_q),
    .img_end_i       (img_end_q),
    .free_address_i  (s_axis_tdata_i[33:2]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_data_o      (m_axis_tdata_o)
  );

endmodule
